// File: rtl/fsub_pkg.sv
// Shared types and constants for the first_substring_match block.
// No dependencies; imported by fsub_cell, first_substring_match and the testbench.
`default_nettype none

package fsub_pkg;

    localparam int PATTERN_MAX   = 8;
    localparam int POSITION_BITS = 16;
    localparam int COUNT_BITS    = POSITION_BITS + 1;
    localparam int PATTERN_BITS  = 64;
    localparam int LENGTH_BITS   = 4;
    localparam int BYTE_BITS     = 8;
    localparam int CFG_IDX_BITS  = 2;
    localparam int SEL_BITS      = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_PATTERN_BYTES  = 2'd0,
        CFG_PATTERN_LENGTH = 2'd1
    } fsub_cfg_idx_t;

    typedef struct packed {
        logic                 shift;
        logic                 clear;
        logic                 active;
        logic [BYTE_BITS-1:0] want;
    } fsub_cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/fsub_cell.sv
// One window cell: holds one text byte, passes it to the next cell on
// every accepted beat and compares its incoming byte with a pattern byte.
// Depends on fsub_pkg.
`default_nettype none

module fsub_cell (
    input  wire                          clk,
    input  wire                          rst_n,
    input  fsub_pkg::fsub_cell_ctrl_t    ctrl,
    input  wire [fsub_pkg::BYTE_BITS-1:0] byte_in,
    output logic [fsub_pkg::BYTE_BITS-1:0] byte_out,
    output logic                         hit
);
    import fsub_pkg::*;

    logic [BYTE_BITS-1:0] byte_reg;
    logic [BYTE_BITS-1:0] byte_next;

    always_comb
    begin
        byte_next = byte_reg;
        if (ctrl.shift)
        begin
            byte_next = ctrl.clear ? '0 : byte_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    assign hit      = !ctrl.active || (byte_in == ctrl.want);
    assign byte_out = byte_reg;

endmodule

`default_nettype wire

// File: rtl/first_substring_match.sv
// Top level of the streaming first-occurrence substring search.
// Depends on fsub_pkg and fsub_cell.
//
// Usage:
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 loads
//   the pattern (first byte in bits 7:0), index 1 loads the length (low 4
//   bits). cfg_ready is always high. Write only while no text is in flight.
//   Input stream: one text byte per beat in s_axis_tdata, s_axis_tlast
//   marks the final byte. Bytes are accepted one per clock unless stalled.
//   Output stream: one beat per text, after the tlast input beat.
//   m_axis_tuser is the found flag, m_axis_tdata the start index of the
//   first occurrence (zero when not found).
//   The result beat is registered and valid in the cycle after the tlast beat.
//   Throughput: one byte per cycle unless stalled; the window compare is done
//   in parallel across the row of PATTERN_MAX cells, one byte shifted per beat.
//   A stalled output register holds its beat; input is still taken while
//   the result register is empty or being drained in the same cycle.
//   Reset clears pattern, length, window, position count and output valid.
`default_nettype none

module first_substring_match (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire [fsub_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  wire [fsub_pkg::PATTERN_BITS-1:0]    cfg_data,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire [7:0]                           s_axis_tdata,   // [7:0] text_byte
    input  wire                                 s_axis_tlast,   // is_last
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    output logic [15:0]                         m_axis_tdata,   // [15:0] match_start
    output logic                                m_axis_tuser    // [0] found
);
    import fsub_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = '1;

    logic [PATTERN_BITS-1:0]  pattern_reg;
    logic [LENGTH_BITS-1:0]   length_reg;
    logic [COUNT_BITS-1:0]    count_reg;
    logic [COUNT_BITS-1:0]    count_next;
    logic                     seen_reg;
    logic                     seen_next;
    logic [POSITION_BITS-1:0] start_reg;
    logic [POSITION_BITS-1:0] start_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic                     out_found_reg;
    logic                     out_found_next;
    logic [15:0]              out_start_reg;
    logic [15:0]              out_start_next;

    logic                     accept;
    logic [COUNT_BITS-1:0]    count_inc;
    logic [COUNT_BITS-1:0]    start_calc;
    logic                     len_ok;
    logic                     window_full;
    logic                     capture;
    logic [PATTERN_MAX-1:0]   hits;
    logic [BYTE_BITS-1:0]     cell_bytes [PATTERN_MAX];
    logic [BYTE_BITS-1:0]     pat_bytes  [PATTERN_BITS/BYTE_BITS];

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        for (int k = 0; k < PATTERN_BITS / BYTE_BITS; k++)
        begin
            pat_bytes[k] = pattern_reg[k*BYTE_BITS +: BYTE_BITS];
        end
    end

    // cell i sees window entry i; it must equal pattern byte len-1-i
    for (genvar i = 0; i < PATTERN_MAX; i++)
    begin : g_cell
        fsub_cell_ctrl_t       ctrl;
        logic [LENGTH_BITS-1:0] sel;
        logic [BYTE_BITS-1:0]   cell_in;

        assign sel         = length_reg - LENGTH_BITS'(i + 1);
        assign ctrl.shift  = accept;
        assign ctrl.clear  = s_axis_tlast;
        assign ctrl.active = length_reg > LENGTH_BITS'(i);
        assign ctrl.want   = pat_bytes[sel[SEL_BITS-1:0]];

        if (i == 0)
        begin : g_head
            assign cell_in = s_axis_tdata;
        end
        else
        begin : g_body
            assign cell_in = cell_bytes[i-1];
        end

        fsub_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .byte_in  (cell_in),
            .byte_out (cell_bytes[i]),
            .hit      (hits[i])
        );
    end

    assign count_inc   = (count_reg == COUNT_LIMIT) ? count_reg : count_reg + 1'b1;
    assign len_ok      = (length_reg != '0) && (length_reg <= LENGTH_BITS'(PATTERN_MAX));
    assign window_full = count_inc >= COUNT_BITS'(length_reg);
    assign start_calc  = count_inc - COUNT_BITS'(length_reg);
    assign capture     = !seen_reg && len_ok && window_full && (&hits)
                         && !start_calc[COUNT_BITS-1];

    always_comb
    begin
        count_next     = count_reg;
        seen_next      = seen_reg;
        start_next     = start_reg;
        out_valid_next = out_valid_reg;
        out_found_next = out_found_reg;
        out_start_next = out_start_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            if (s_axis_tlast)
            begin
                out_valid_next = 1'b1;
                out_found_next = seen_reg || capture;
                if (seen_reg)
                begin
                    out_start_next = start_reg[15:0];
                end
                else if (capture)
                begin
                    out_start_next = start_calc[15:0];
                end
                else
                begin
                    out_start_next = '0;
                end
                count_next = '0;
                seen_next  = 1'b0;
                start_next = '0;
            end
            else
            begin
                count_next = count_inc;
                if (capture)
                begin
                    seen_next  = 1'b1;
                    start_next = start_calc[POSITION_BITS-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            length_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_PATTERN_BYTES:  pattern_reg <= cfg_data;
                CFG_PATTERN_LENGTH: length_reg  <= cfg_data[LENGTH_BITS-1:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            seen_reg      <= 1'b0;
            start_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_found_reg <= 1'b0;
            out_start_reg <= '0;
        end
        else
        begin
            count_reg     <= count_next;
            seen_reg      <= seen_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
            out_found_reg <= out_found_next;
            out_start_reg <= out_start_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_start_reg;
    assign m_axis_tuser  = out_found_reg;

endmodule

`default_nettype wire

// File: verif/first_substring_match_tb.sv
// Self-checking testbench for first_substring_match: streams texts, predicts the
// first-match result of each text and checks every output beat. Depends on fsub_pkg and first_substring_match.
`timescale 1ns / 100ps

typedef struct packed {
    logic        found;
    logic [15:0] start;
} search_outcome_t;

class match_tracker;
    logic [fsub_pkg::PATTERN_BITS-1:0] pattern;
    logic [fsub_pkg::LENGTH_BITS-1:0]  pattern_len;
    logic [7:0]                        window [fsub_pkg::PATTERN_MAX];
    logic [fsub_pkg::COUNT_BITS-1:0]   bytes_seen;
    bit                                match_held;
    logic [15:0]                       match_pos;
    search_outcome_t                   outcomes_due [$];
    int                                errors;

    function void clear_text();
        for (int i = 0; i < fsub_pkg::PATTERN_MAX; i++)
            window[i] = 8'h00;
        bytes_seen = '0;
        match_held = 1'b0;
        match_pos  = 16'h0000;
    endfunction

    function void reset_all();
        pattern     = '0;
        pattern_len = '0;
        errors      = 0;
        outcomes_due.delete();
        clear_text();
    endfunction

    function void write_reg(fsub_pkg::fsub_cfg_idx_t idx,
                            logic [fsub_pkg::PATTERN_BITS-1:0] data);
        case (idx)
            fsub_pkg::CFG_PATTERN_BYTES:  pattern     = data;
            fsub_pkg::CFG_PATTERN_LENGTH: pattern_len = data[fsub_pkg::LENGTH_BITS-1:0];
            default: ;
        endcase
    endfunction

    function bit window_hit();
        int len;
        bit hit;
        len = pattern_len;
        if (len == 0 || len > fsub_pkg::PATTERN_MAX || bytes_seen < len)
            return 1'b0;
        hit = 1'b1;
        for (int k = 0; k < len; k++)
            if (window[len - 1 - k] != pattern[8*k +: 8])
                hit = 1'b0;
        return hit;
    endfunction

    function void note_text_byte(logic [7:0] b, logic last);
        logic [fsub_pkg::COUNT_BITS-1:0] first;
        search_outcome_t res;
        for (int i = fsub_pkg::PATTERN_MAX - 1; i > 0; i--)
            window[i] = window[i-1];
        window[0] = b;
        if (bytes_seen != '1)
            bytes_seen = bytes_seen + 1'b1;
        if (!match_held && window_hit()) begin
            first = bytes_seen - pattern_len;
            // starts past the position range are dropped
            if (first[fsub_pkg::POSITION_BITS] == 1'b0) begin
                match_held = 1'b1;
                match_pos  = first[15:0];
            end
        end
        if (last) begin
            res.found = match_held;
            res.start = match_held ? match_pos : 16'h0000;
            outcomes_due.push_back(res);
            clear_text();
        end
    endfunction

    task report(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    task check_outcome(logic found, logic [15:0] start);
        search_outcome_t want;
        if (outcomes_due.size() == 0) begin
            report($sformatf("result beat with none due (found=%0b start=%0d)", found, start));
            return;
        end
        want = outcomes_due.pop_front();
        if (found !== want.found)
            report($sformatf("found %0b, predicted %0b", found, want.found));
        if (start !== want.start)
            report($sformatf("match_start %0d, predicted %0d", start, want.start));
    endtask

    function int pending();
        return outcomes_due.size();
    endfunction
endclass

module first_substring_match_tb;
    import fsub_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 4;
    localparam int RANDOM_ITEMS = 1600;

    typedef enum int {READY_ALWAYS, READY_RANDOM, READY_BURSTY} sink_mode_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [PATTERN_BITS-1:0]  cfg_data = '0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [7:0]               s_axis_tdata = 8'h00;
    logic                     s_axis_tlast = 1'b0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [15:0]              m_axis_tdata;
    logic                     m_axis_tuser;

    match_tracker             tracker;
    sink_mode_t               sink_mode = READY_ALWAYS;
    int                       stall_left = 0;
    bit                       gaps_on = 1'b0;
    int                       burst_left = 0;
    int                       cycles = 0;
    int                       random_sent = 0;
    logic [PATTERN_BITS-1:0]  cur_pattern = '0;
    int                       cur_len = 0;
    logic [7:0]               text_buf [$];

    first_substring_match DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // monitors: config writes, result beats, then text beats
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (cfg_valid && cfg_ready)
                tracker.write_reg(fsub_cfg_idx_t'(cfg_index), cfg_data);
            if (m_axis_tvalid && m_axis_tready)
                tracker.check_outcome(m_axis_tuser, m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                tracker.note_text_byte(s_axis_tdata, s_axis_tlast);
        end
    end

    always @(negedge clk)
    begin
        case (sink_mode)
            READY_ALWAYS: m_axis_tready <= 1'b1;
            READY_RANDOM: m_axis_tready <= ($urandom_range(0, 2) != 0);
            default:
            begin
                if (stall_left > 0) begin
                    stall_left--;
                    m_axis_tready <= 1'b0;
                end else begin
                    m_axis_tready <= 1'b1;
                    stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
                end
            end
        endcase
    end

    // called at a falling edge, returns at a falling edge with cfg_valid low
    task configure(input logic [PATTERN_BITS-1:0] pat, input logic [3:0] len);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_PATTERN_BYTES;
        cfg_data  <= pat;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_index <= CFG_PATTERN_LENGTH;
        cfg_data  <= {{(PATTERN_BITS-4){1'b0}}, len};
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid   <= 1'b0;
        cur_pattern = pat;
        cur_len     = int'(len);
    endtask

    task send_beat(input logic [7:0] b, input logic last);
        if (gaps_on) begin
            if (burst_left == 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
                burst_left = $urandom_range(1, 16);
            end
            burst_left--;
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
    endtask

    task send_text(input bit with_last);
        for (int i = 0; i < text_buf.size(); i++)
            send_beat(text_buf[i], with_last && (i == text_buf.size() - 1));
    endtask

    task quiesce();
        s_axis_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task random_search_setup();
        int pick;
        logic [PATTERN_BITS-1:0] pat;
        logic [3:0] len;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            len = 4'($urandom_range(1, 8));
        else if (pick == 7)
            len = 4'd0;
        else if (pick == 8)
            len = 4'($urandom_range(9, 15));
        else
            len = 4'd8;
        if ($urandom_range(0, 1) == 0) begin
            pat = {$urandom, $urandom};
        end else begin
            // narrow alphabet gives repeats and near misses
            for (int k = 0; k < PATTERN_MAX; k++)
                case ($urandom_range(0, 3))
                    0: pat[8*k +: 8] = 8'h00;
                    1: pat[8*k +: 8] = 8'h41;
                    2: pat[8*k +: 8] = 8'h42;
                    default: pat[8*k +: 8] = 8'hFF;
                endcase
        end
        configure(pat, len);
    endtask

    task build_random_text();
        int n;
        int alpha;
        int at;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 24);
        alpha = $urandom_range(0, 3);
        text_buf.delete();
        for (int i = 0; i < n; i++) begin
            if (alpha == 0 || $urandom_range(0, 4) == 0)
                text_buf.push_back(8'($urandom_range(0, 255)));
            else
                text_buf.push_back(cur_pattern[8*$urandom_range(0, 7) +: 8]);
        end
        if (cur_len >= 1 && cur_len <= PATTERN_MAX && n >= cur_len) begin
            repeat ($urandom_range(0, 2)) begin
                at = $urandom_range(0, n - cur_len);
                for (int k = 0; k < cur_len; k++)
                    text_buf[at + k] = cur_pattern[8*k +: 8];
            end
        end
    endtask

    task load_text(input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2, input int n);
        text_buf.delete();
        if (n > 0) text_buf.push_back(b0);
        if (n > 1) text_buf.push_back(b1);
        if (n > 2) text_buf.push_back(b2);
    endtask

    initial
    begin
        tracker = new();
        tracker.reset_all();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // zero length after reset, zero byte text
        load_text(8'h00, 8'h00, 8'h00, 1);
        send_text(1'b1);
        quiesce();

        // full-width pattern of all ones, matched at index 0
        configure({PATTERN_BITS{1'b1}}, 4'd8);
        text_buf.delete();
        repeat (8) text_buf.push_back(8'hFF);
        send_text(1'b1);
        quiesce();

        // zero bytes as pattern data, then a text shorter than the pattern
        configure('0, 4'd2);
        load_text(8'h05, 8'h00, 8'h00, 3);
        send_text(1'b1);
        load_text(8'h00, 8'h00, 8'h00, 1);
        send_text(1'b1);
        quiesce();

        // length beyond the window never matches
        configure('0, 4'd15);
        load_text(8'h00, 8'h00, 8'h00, 3);
        send_text(1'b1);
        quiesce();

        // capture survives a config change inside a text
        configure(64'h0201, 4'd2);
        load_text(8'h01, 8'h02, 8'h00, 2);
        send_text(1'b0);
        quiesce();
        configure(64'h77, 4'd1);
        load_text(8'h77, 8'h00, 8'h00, 1);
        send_text(1'b1);
        quiesce();

        while (random_sent < RANDOM_ITEMS) begin
            random_search_setup();
            sink_mode  = sink_mode_t'($urandom_range(0, 2));
            gaps_on    = ($urandom_range(0, 3) != 0);
            burst_left = 0;
            repeat ($urandom_range(1, 6)) begin
                build_random_text();
                send_text(1'b1);
                random_sent += text_buf.size();
            end
            quiesce();
        end

        if (tracker.pending() != 0)
            tracker.report($sformatf("%0d results never arrived", tracker.pending()));
        if (tracker.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
